// ===== hw/rtl/unordered_array_list_table_defines.svh =====
// Assertion macros for the unordered array list table.
// The asserting module must have clk_i and rst_ni in scope.
`ifndef UNORDERED_ARRAY_LIST_TABLE_DEFINES_SVH
`define UNORDERED_ARRAY_LIST_TABLE_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define UAT_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("Assertion failed.");

`define UAT_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("Assertion failed.");

`else

`define UAT_ASSERT(name, prop)

`define UAT_ASSERT_NEXT(name, ante, cons)

`endif

`endif

// ===== hw/rtl/uat_pkg.sv =====
// Package for the unordered array list table: sizes, codes and control structs.
// Used by uat_cell, uat_find and unordered_array_list_table.
`timescale 1ns / 1ps

package uat_pkg;

  localparam int CAPACITY = 128;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int INDEX_W  = 7;
  localparam int FILL_W   = 8;

  localparam int GROUP    = 8;
  localparam int GRP_W    = $clog2(GROUP);
  localparam int NGROUPS  = (CAPACITY + GROUP - 1) / GROUP;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_GRP  = 4'b0010,
    S_SEL  = 4'b0100,
    S_UPD  = 4'b1000
  } state_e;

  typedef struct packed {
    logic              cmp_en;
    logic [DATA_W-1:0] key;
    logic              ins_en;
    logic              shift_en;
    logic [CNT_W-1:0]  count;
    logic [IDX_W-1:0]  pos;
  } cell_ctrl_t;

  typedef struct packed {
    logic grp_en;
    logic sel_en;
  } find_ctrl_t;

endpackage

// ===== hw/rtl/uat_cell.sv =====
// One storage cell of the list chain: holds an entry and its registered key match.
// Depends on uat_pkg.
`timescale 1ns / 1ps

module uat_cell (
  input  logic                         clk_i,
  input  uat_pkg::cell_ctrl_t          ctrl_i,
  input  logic [uat_pkg::IDX_W-1:0]    idx_i,
  input  logic [uat_pkg::DATA_W-1:0]   next_data_i,
  output logic [uat_pkg::DATA_W-1:0]   data_o,
  output logic                         match_o
);
  import uat_pkg::*;

  logic [DATA_W-1:0] data_q;
  logic              match_q;
  logic [CNT_W-1:0]  idx_ext;
  logic              occupied;

  assign idx_ext  = CNT_W'(idx_i);
  assign occupied = idx_ext < ctrl_i.count;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cmp_en) begin
      match_q <= occupied && (data_q == ctrl_i.key);
    end
    if (ctrl_i.ins_en && (idx_ext == ctrl_i.count)) begin
      data_q <= ctrl_i.key;
    end else if (ctrl_i.shift_en && (idx_i >= ctrl_i.pos)) begin
      data_q <= next_data_i;
    end
  end

  assign data_o  = data_q;
  assign match_o = match_q;

endmodule

// ===== hw/rtl/uat_find.sv =====
// Two-stage registered priority encoder that finds the lowest matching cell.
// Depends on uat_pkg.
`timescale 1ns / 1ps

module uat_find (
  input  logic                          clk_i,
  input  uat_pkg::find_ctrl_t           ctrl_i,
  input  logic [uat_pkg::CAPACITY-1:0]  match_i,
  output logic                          hit_o,
  output logic [uat_pkg::IDX_W-1:0]     pos_o
);
  import uat_pkg::*;

  logic [NGROUPS*GROUP-1:0] padded;
  logic [NGROUPS-1:0]       grp_any_d, grp_any_q;
  logic [GRP_W-1:0]         grp_loc_d [NGROUPS];
  logic [GRP_W-1:0]         grp_loc_q [NGROUPS];
  logic                     hit_d, hit_q;
  logic [IDX_W-1:0]         pos_d, pos_q;

  assign padded = (NGROUPS*GROUP)'(match_i);

  always_comb begin
    for (int g = 0; g < NGROUPS; g++) begin
      grp_any_d[g] = 1'b0;
      grp_loc_d[g] = '0;
      for (int b = GROUP - 1; b >= 0; b--) begin
        if (padded[g*GROUP + b]) begin
          grp_any_d[g] = 1'b1;
          grp_loc_d[g] = GRP_W'(b);
        end
      end
    end
  end

  always_comb begin
    hit_d = 1'b0;
    pos_d = '0;
    for (int g = NGROUPS - 1; g >= 0; g--) begin
      if (grp_any_q[g]) begin
        hit_d = 1'b1;
        pos_d = IDX_W'(g*GROUP + int'(grp_loc_q[g]));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.grp_en) begin
      grp_any_q <= grp_any_d;
      grp_loc_q <= grp_loc_d;
    end
    if (ctrl_i.sel_en) begin
      hit_q <= hit_d;
      pos_q <= pos_d;
    end
  end

  assign hit_o = hit_q;
  assign pos_o = pos_q;

endmodule

// ===== hw/rtl/unordered_array_list_table.sv =====
// Top level of the unordered array list table: control, cell chain and result register.
// Depends on uat_pkg, uat_cell, uat_find and unordered_array_list_table_defines.svh.
// The block stores up to 128 signed 32-bit values in insertion order in a chain of
// cells and serves one request at a time. An insert or an unused command code goes from
// idle straight to the update state, and a search or remove passes the group and select
// states first, since all cells compare the key at once, a two-level priority encoder then
// finds the lowest match over two registered steps, and the shift runs in the final
// step. The next beat is taken in the cycle after the result is loaded into the output
// register, so a new request waits until the last one is answered and the output is free.
`timescale 1ns / 1ps
`include "unordered_array_list_table_defines.svh"

module unordered_array_list_table (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [uat_pkg::CMD_W-1:0]      cmd_i,
  input  logic signed [uat_pkg::DATA_W-1:0] value_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [uat_pkg::STATUS_W-1:0]   status_o,
  output logic [uat_pkg::INDEX_W-1:0]    found_index_o,
  output logic [uat_pkg::FILL_W-1:0]     fill_count_o
);
  import uat_pkg::*;

  state_e              state_d, state_q;
  logic [CMD_W-1:0]    cmd_q;
  logic [DATA_W-1:0]   key_q;
  logic [CNT_W-1:0]    count_d, count_q;
  logic                out_valid_d, out_valid_q;
  logic [STATUS_W-1:0] status_d, status_q;
  logic [INDEX_W-1:0]  index_d, index_q;
  logic [FILL_W-1:0]   fill_d, fill_q;

  logic                accept, out_free, fire;
  logic                is_ins, is_srch, is_rem, full;
  logic                hit;
  logic [IDX_W-1:0]    pos;
  logic [31:0]         pos_ext, cnt_ext;

  cell_ctrl_t          cell_ctrl;
  find_ctrl_t          find_ctrl;
  logic [DATA_W-1:0]   cell_data [CAPACITY];
  logic [DATA_W-1:0]   next_data [CAPACITY];
  logic [CAPACITY-1:0] match_vec;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign fire     = (state_q == S_UPD) && out_free;

  assign is_ins  = (cmd_q == CMD_INSERT);
  assign is_srch = (cmd_q == CMD_SEARCH);
  assign is_rem  = (cmd_q == CMD_REMOVE);
  assign full    = count_q >= CNT_W'(CAPACITY);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if ((cmd_i == CMD_SEARCH) || (cmd_i == CMD_REMOVE)) begin
            state_d = S_GRP;
          end else begin
            state_d = S_UPD;
          end
        end
      end
      S_GRP: begin
        state_d = S_SEL;
      end
      S_SEL: begin
        state_d = S_UPD;
      end
      S_UPD: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    count_d  = count_q;
    status_d = ST_NOTFOUND;
    index_d  = '0;
    if (is_ins) begin
      if (full) begin
        status_d = ST_FULL;
      end else begin
        status_d = ST_OK;
        count_d  = count_q + CNT_W'(1);
      end
    end else if ((is_srch || is_rem) && hit) begin
      status_d = ST_OK;
      index_d  = pos_ext[INDEX_W-1:0];
      if (is_rem) begin
        count_d = count_q - CNT_W'(1);
      end
    end
  end

  assign pos_ext = 32'(pos);
  assign cnt_ext = 32'(count_d);
  assign fill_d  = cnt_ext[FILL_W-1:0];

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (fire) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
      key_q <= value_i;
    end
    if (fire) begin
      status_q <= status_d;
      index_q  <= index_d;
      fill_q   <= fill_d;
    end
  end

  assign cell_ctrl.cmp_en   = accept;
  assign cell_ctrl.key      = (state_q == S_IDLE) ? value_i : key_q;
  assign cell_ctrl.ins_en   = fire && is_ins && !full;
  assign cell_ctrl.shift_en = fire && is_rem && hit;
  assign cell_ctrl.count    = count_q;
  assign cell_ctrl.pos      = pos;

  assign find_ctrl.grp_en = (state_q == S_GRP);
  assign find_ctrl.sel_en = (state_q == S_SEL);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == CAPACITY - 1) begin : g_last
      assign next_data[i] = cell_data[i];
    end else begin : g_mid
      assign next_data[i] = cell_data[i+1];
    end

    uat_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (cell_ctrl),
      .idx_i       (IDX_W'(i)),
      .next_data_i (next_data[i]),
      .data_o      (cell_data[i]),
      .match_o     (match_vec[i])
    );
  end

  uat_find u_find (
    .clk_i   (clk_i),
    .ctrl_i  (find_ctrl),
    .match_i (match_vec),
    .hit_o   (hit),
    .pos_o   (pos)
  );

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign found_index_o = index_q;
  assign fill_count_o  = fill_q;

  `UAT_ASSERT(a_count_in_range, count_q <= CNT_W'(CAPACITY))
  `UAT_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, state_q != S_IDLE)
  `UAT_ASSERT_NEXT(a_count_only_on_fire, !fire, $stable(count_q))
  `UAT_ASSERT(a_result_from_update, $rose(out_valid_q) |-> ($past(state_q) == S_UPD))

endmodule

// ===== sim/unordered_array_list_table_tb.sv =====
// Self-checking testbench for the unordered array list table: a directed table of
// requests followed by phased random traffic, checked against literal expected results or a queue-based predictor.
// Depends on uat_pkg and the unordered_array_list_table RTL.
`timescale 1ns / 1ps

module unordered_array_list_table_tb;
  import uat_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1330;
  localparam int HOLD_CYCLES  = 400;

  typedef struct packed {
    status_e             status;
    logic [INDEX_W-1:0]  index;
    logic [FILL_W-1:0]   fill;
  } result_t;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [DATA_W-1:0]  value;
    logic               typed;
    result_t            lit;
  } step_t;

  typedef enum int {PH_FILL, PH_MIX, PH_DRAIN} phase_e;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic [CMD_W-1:0]          cmd_i = CMD_INSERT;
  logic signed [DATA_W-1:0]  value_i = '0;
  logic                      out_stall_i = 1'b0;
  logic                      in_stall_o;
  logic                      out_valid_o;
  logic [STATUS_W-1:0]       status_o;
  logic [INDEX_W-1:0]        found_index_o;
  logic [FILL_W-1:0]         fill_count_o;

  logic [DATA_W-1:0] list_model[$];
  result_t           pending_results[$];
  logic [DATA_W-1:0] value_pool[16];

  int fail_count = 0;
  int holds_wanted = 0;
  int holds_done = 0;
  int burst_left = 0;
  int n_insert = 0, n_full = 0, n_search = 0, n_remove = 0, n_miss = 0, n_unused = 0;
  int peak_fill = 0;

  step_t directed_steps[24] = '{
    '{CMD_SEARCH, 32'h0000_0000, 1'b1, '{ST_NOTFOUND, 7'd0, 8'd0}},
    '{CMD_REMOVE, 32'h0000_0000, 1'b1, '{ST_NOTFOUND, 7'd0, 8'd0}},
    '{CMD_UNUSED, 32'h0000_0000, 1'b1, '{ST_NOTFOUND, 7'd0, 8'd0}},
    '{CMD_INSERT, 32'h8000_0000, 1'b1, '{ST_OK, 7'd0, 8'd1}},
    '{CMD_INSERT, 32'h7FFF_FFFF, 1'b1, '{ST_OK, 7'd0, 8'd2}},
    '{CMD_INSERT, 32'h0000_0000, 1'b1, '{ST_OK, 7'd0, 8'd3}},
    '{CMD_INSERT, 32'hFFFF_FFFF, 1'b1, '{ST_OK, 7'd0, 8'd4}},
    '{CMD_INSERT, 32'h7FFF_FFFF, 1'b1, '{ST_OK, 7'd0, 8'd5}},
    '{CMD_SEARCH, 32'h7FFF_FFFF, 1'b1, '{ST_OK, 7'd1, 8'd5}},
    '{CMD_SEARCH, 32'h8000_0000, 1'b0, '{ST_OK, 7'd0, 8'd0}},
    '{CMD_SEARCH, 32'hFFFF_FFFF, 1'b0, '{ST_OK, 7'd0, 8'd0}},
    '{CMD_SEARCH, 32'h0000_0005, 1'b1, '{ST_NOTFOUND, 7'd0, 8'd5}},
    '{CMD_UNUSED, 32'hFFFF_FFFF, 1'b1, '{ST_NOTFOUND, 7'd0, 8'd5}},
    '{CMD_REMOVE, 32'h7FFF_FFFF, 1'b1, '{ST_OK, 7'd1, 8'd4}},
    '{CMD_SEARCH, 32'h7FFF_FFFF, 1'b0, '{ST_OK, 7'd0, 8'd0}},
    '{CMD_REMOVE, 32'h8000_0000, 1'b0, '{ST_OK, 7'd0, 8'd0}},
    '{CMD_REMOVE, 32'h0001_2345, 1'b1, '{ST_NOTFOUND, 7'd0, 8'd3}},
    '{CMD_REMOVE, 32'h7FFF_FFFF, 1'b0, '{ST_OK, 7'd0, 8'd0}},
    '{CMD_REMOVE, 32'h0000_0000, 1'b0, '{ST_OK, 7'd0, 8'd0}},
    '{CMD_REMOVE, 32'hFFFF_FFFF, 1'b0, '{ST_OK, 7'd0, 8'd0}},
    '{CMD_REMOVE, 32'hFFFF_FFFF, 1'b1, '{ST_NOTFOUND, 7'd0, 8'd0}},
    '{CMD_INSERT, 32'h5555_5555, 1'b0, '{ST_OK, 7'd0, 8'd0}},
    '{CMD_INSERT, 32'hAAAA_AAAA, 1'b0, '{ST_OK, 7'd0, 8'd0}},
    '{CMD_SEARCH, 32'hAAAA_AAAA, 1'b0, '{ST_OK, 7'd0, 8'd0}}
  };

  unordered_array_list_table u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .found_index_o (found_index_o),
    .fill_count_o  (fill_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic result_t apply_request(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] key);
    result_t r;
    int      pos;
    r.status = ST_NOTFOUND;
    r.index  = '0;
    pos      = -1;
    case (cmd)
      CMD_INSERT: begin
        if (list_model.size() >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          list_model.push_back(key);
          r.status = ST_OK;
        end
      end
      CMD_SEARCH, CMD_REMOVE: begin
        for (int i = 0; i < list_model.size(); i++) begin
          if (pos < 0 && list_model[i] == key) begin
            pos = i;
          end
        end
        if (pos >= 0) begin
          r.status = ST_OK;
          r.index  = INDEX_W'(pos);
          if (cmd == CMD_REMOVE) begin
            list_model.delete(pos);
          end
        end
      end
      default: ;
    endcase
    r.fill = FILL_W'(list_model.size());
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    int n;
    n = $urandom_range(0, 99);
    if (n < 60) begin
      return value_pool[$urandom_range(0, 15)];
    end
    return $urandom();
  endfunction

  function automatic logic [DATA_W-1:0] pick_key();
    if (list_model.size() > 0 && $urandom_range(0, 99) < 60) begin
      return list_model[$urandom_range(0, list_model.size() - 1)];
    end
    return pick_value();
  endfunction

  function automatic logic [CMD_W-1:0] pick_cmd(phase_e phase);
    int n;
    int ins_pct;
    int srch_pct;
    n = $urandom_range(0, 99);
    case (phase)
      PH_FILL: begin
        ins_pct  = 80;
        srch_pct = 10;
      end
      PH_DRAIN: begin
        ins_pct  = 10;
        srch_pct = 15;
      end
      default: begin
        ins_pct  = 35;
        srch_pct = 35;
      end
    endcase
    if (n < 3) return CMD_UNUSED;
    if (n < 3 + ins_pct) return CMD_INSERT;
    if (n < 3 + ins_pct + srch_pct) return CMD_SEARCH;
    return CMD_REMOVE;
  endfunction

  task automatic send_request(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] value,
                              logic typed, result_t lit);
    result_t want;
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    value_i    <= value;
    do begin
      @(posedge clk_i);
    end while (in_stall_o !== 1'b0);
    want = apply_request(cmd, value);
    case (cmd)
      CMD_INSERT: begin
        n_insert++;
        if (want.status == ST_FULL) n_full++;
      end
      CMD_SEARCH: n_search++;
      CMD_REMOVE: n_remove++;
      default:    n_unused++;
    endcase
    if (want.status == ST_NOTFOUND) n_miss++;
    if (list_model.size() > peak_fill) peak_fill = list_model.size();
    pending_results.push_back(typed ? lit : want);
    @(negedge clk_i);
  endtask

  task automatic idle_sender();
    int n;
    int gap;
    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      n = $urandom_range(0, 99);
      if (n < 4) begin
        burst_left = $urandom_range(30, 90);
      end else if (n >= 50 && n < 95) begin
        gap = $urandom_range(1, 3);
      end else if (n >= 95) begin
        gap = $urandom_range(10, 40);
      end
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin : sender
    phase_e           phase;
    int               phase_left;
    int               accepted;
    logic [CMD_W-1:0] cmd;
    logic [DATA_W-1:0] value;
    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'hFFFF_FFFF;
    value_pool[2] = 32'h8000_0000;
    value_pool[3] = 32'h7FFF_FFFF;
    for (int i = 4; i < 16; i++) begin
      value_pool[i] = $urandom();
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_steps[i]) begin
      send_request(directed_steps[i].cmd, directed_steps[i].value,
                   directed_steps[i].typed, directed_steps[i].lit);
      idle_sender();
    end
    drain_results();

    phase      = PH_FILL;
    phase_left = 220;
    accepted   = 0;
    while (accepted < RANDOM_ITEMS) begin
      if (phase_left == 0) begin
        phase      = phase_e'($urandom_range(0, 2));
        phase_left = $urandom_range(120, 240);
      end
      phase_left--;
      cmd   = pick_cmd(phase);
      value = (cmd == CMD_INSERT) ? pick_value() : pick_key();
      send_request(cmd, value, 1'b0, '0);
      if (cmd != CMD_UNUSED) begin
        accepted++;
        if (accepted == 300 || accepted == 900) holds_wanted++;
      end
      if (cmd != CMD_UNUSED && accepted == 600) begin
        drain_results();
      end else begin
        idle_sender();
      end
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Run covered %0d inserts (%0d rejected as full), %0d searches, %0d removes,",
             n_insert, n_full, n_search, n_remove);
    $display("%0d unused codes and %0d not-found answers; peak fill %0d of %0d.",
             n_unused, n_miss, peak_fill, CAPACITY);
    if (fail_count == 0) begin
      $display("PASS unordered_array_list_table");
    end else begin
      $display("FAIL unordered_array_list_table");
    end
    $finish;
  end

  initial begin : receiver
    int n;
    forever begin
      @(negedge clk_i);
      if (holds_wanted > holds_done) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        holds_done++;
        out_stall_i <= 1'b0;
      end else if (burst_left > 0) begin
        out_stall_i <= 1'b0;
      end else begin
        n = $urandom_range(0, 99);
        if (n < 70) begin
          out_stall_i <= 1'b0;
        end else if (n < 95) begin
          out_stall_i <= 1'b1;
          repeat ($urandom_range(0, 2)) @(negedge clk_i);
        end else begin
          out_stall_i <= 1'b1;
          repeat ($urandom_range(8, 30)) @(negedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_results.size() == 0) begin
        if (fail_count < 10) begin
          $display("Unexpected result beat: status %0d index %0d fill %0d",
                   status_o, found_index_o, fill_count_o);
        end
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status || found_index_o !== want.index ||
            fill_count_o !== want.fill) begin
          if (fail_count < 10) begin
            $display("Mismatch: expected status %0d index %0d fill %0d, got %0d %0d %0d",
                     want.status, want.index, want.fill,
                     status_o, found_index_o, fill_count_o);
          end
          fail_count++;
        end
      end
    end
  end

  initial begin : watchdog
    #(5_000_000);
    $display("FAIL unordered_array_list_table");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/uat_pkg.sv
hw/rtl/uat_cell.sv
hw/rtl/uat_find.sv
hw/rtl/unordered_array_list_table.sv
sim/unordered_array_list_table_tb.sv
